[rtl/core/signed_int_to_decimal_ascii_core_defines.svh]
// Assertion helpers; they compile away in synthesis.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SIDTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sidta assertion failed");
`define SIDTA_NEVER(lbl, cond) `SIDTA_ASSERT(lbl, !(cond))
`else
`define SIDTA_ASSERT(lbl, prop)
`define SIDTA_NEVER(lbl, cond)
`endif

`endif

[rtl/core/sidta_pkg.sv]
`default_nettype none

package sidta_pkg;

  localparam int unsigned ValueWidth        = 32;
  localparam int unsigned CharWidth         = 8;
  localparam int unsigned MultWidth         = 34;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [3:0]           TopPow    = 4'd9;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkSign,
    BkDigit
  } back_state_e;

  function automatic logic [MultWidth-1:0] pow10(input logic [3:0] k);
    logic [MultWidth-1:0] p;
    unique case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

  // d times ten to the k; both indexes are small, so this folds into a constant table
  function automatic logic [MultWidth-1:0] multiple(input logic [3:0] k, input logic [3:0] d);
    logic [MultWidth-1:0] p;
    p = pow10(k);
    return p * {{(MultWidth-4){1'b0}}, d};
  endfunction

endpackage

`default_nettype wire

[rtl/core/sidta_if.sv]
`default_nettype none

interface sidta_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sidta_pkg::ValueWidth-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface sidta_out_if;
  logic                              valid;
  logic                              ready;
  logic [sidta_pkg::CharWidth-1:0]   character;
  logic                              last;

  modport source(output valid, output character, output last, input ready);
  modport sink(input valid, input character, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/sidta_front.sv]
`default_nettype none

module sidta_front (
  sidta_in_if.sink          in_i,
  input  wire logic         full_i,
  output logic              push_o,
  output sidta_pkg::job_t   job_o
);

  logic [sidta_pkg::ValueWidth-1:0] raw;

  assign raw       = in_i.value;
  assign in_i.ready = !full_i;
  assign push_o    = in_i.valid && !full_i;

  // take the magnitude as unsigned so the most negative value survives
  always_comb begin
    job_o.neg = raw[sidta_pkg::ValueWidth-1];
    job_o.mag = job_o.neg ? (~raw + {{(sidta_pkg::ValueWidth-1){1'b0}}, 1'b1}) : raw;
  end

endmodule

`default_nettype wire

[rtl/core/sidta_queue.sv]
`default_nettype none

module sidta_queue #(
  parameter int unsigned Depth = sidta_pkg::QueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sidta_pkg::job_t job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output sidta_pkg::job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  sidta_pkg::job_t entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sidta_back.sv]
`default_nettype none

module sidta_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire sidta_pkg::job_t job_i,
  output logic                 job_pop_o,
  sidta_out_if.source          out_o
);

  localparam int unsigned VW = sidta_pkg::ValueWidth;
  localparam int unsigned MW = sidta_pkg::MultWidth;
  localparam int unsigned CW = sidta_pkg::CharWidth;

  sidta_pkg::back_state_e state_q, state_d;
  logic [VW-1:0]  rem_q, rem_d;
  logic [3:0]     pow_q, pow_d;
  logic           started_q, started_d;

  logic [3:0]     dig;
  logic [MW-1:0]  sub_v;
  logic           emit, emit_last, advance, can_load, finish;
  logic [CW-1:0]  emit_char;

  logic           out_valid_q;
  logic [CW-1:0]  char_q;
  logic           last_q;

  assign can_load = !out_valid_q || out_o.ready;

  // digit at the current power: nine independent compares against constant multiples
  always_comb begin
    dig = 4'd0;
    for (int d = 1; d < 10; d++) begin
      if ({{(MW-VW){1'b0}}, rem_q} >= sidta_pkg::multiple(pow_q, 4'(d))) begin
        dig = 4'(d);
      end
    end
    sub_v = sidta_pkg::multiple(pow_q, dig);
  end

  // outputs of the sequencer
  always_comb begin
    emit      = 1'b0;
    emit_char = sidta_pkg::CharZero;
    emit_last = 1'b0;
    unique case (state_q)
      sidta_pkg::BkIdle: begin
        emit = 1'b0;
      end
      sidta_pkg::BkSign: begin
        emit      = 1'b1;
        emit_char = sidta_pkg::CharMinus;
      end
      sidta_pkg::BkDigit: begin
        // drop leading zeros, but always show the units digit
        emit      = (dig != 4'd0) || started_q || (pow_q == 4'd0);
        emit_char = sidta_pkg::CharZero + {4'd0, dig};
        emit_last = (pow_q == 4'd0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign advance   = !emit || can_load;
  assign finish    = (state_q == sidta_pkg::BkDigit) && (pow_q == 4'd0) && advance;
  assign job_pop_o = job_valid_i && ((state_q == sidta_pkg::BkIdle) || finish);

  // next state
  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    pow_d     = pow_q;
    started_d = started_q;
    unique case (state_q)
      sidta_pkg::BkIdle: begin
        state_d = state_q;
      end
      sidta_pkg::BkSign: begin
        if (advance) begin
          state_d = sidta_pkg::BkDigit;
        end
      end
      sidta_pkg::BkDigit: begin
        if (advance) begin
          rem_d     = rem_q - sub_v[VW-1:0];
          pow_d     = pow_q - 4'd1;
          started_d = started_q || emit;
          if (pow_q == 4'd0) begin
            state_d = sidta_pkg::BkIdle;
          end
        end
      end
      default: begin
        state_d = sidta_pkg::BkIdle;
      end
    endcase
    if (job_pop_o) begin
      rem_d     = job_i.mag;
      pow_d     = sidta_pkg::TopPow;
      started_d = 1'b0;
      state_d   = job_i.neg ? sidta_pkg::BkSign : sidta_pkg::BkDigit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sidta_pkg::BkIdle;
      pow_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pow_q     <= pow_d;
      started_q <= started_d;
      if (can_load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (emit && can_load) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

endmodule

`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii_core.sv]
// Signed 32-bit integer to decimal ASCII, streamed one character per word, most
// significant first, with a leading '-' for negative values and the last flag on
// the units digit. The digit sequencer visits all ten decimal powers, one per
// cycle unless a character waits on a stalled output register, after a sign
// state for negative values; powers above the leading digit give no output word.
// A queue of QueueDepth numbers sits between the input side and the sequencer,
// so input words are taken while earlier numbers are printed, and the characters
// leave through an output register that holds under back-pressure.
`default_nettype none
`include "signed_int_to_decimal_ascii_core_defines.svh"

module signed_int_to_decimal_ascii_core #(
  parameter int unsigned QueueDepth = sidta_pkg::QueueDepthDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sidta_in_if.sink     in_i,
  sidta_out_if.source  out_o
);

  sidta_pkg::job_t push_job, head_job;
  logic            push, full, head_valid, head_pop;

  sidta_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  sidta_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  sidta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (head_pop),
    .out_o       (out_o)
  );

  `SIDTA_ASSERT(a_char_legal, out_o.valid |-> (out_o.character == sidta_pkg::CharMinus || (out_o.character >= sidta_pkg::CharZero && out_o.character <= sidta_pkg::CharZero + 8'd9)))
  `SIDTA_ASSERT(a_sign_not_last, (out_o.valid && out_o.last) |-> (out_o.character != sidta_pkg::CharMinus))
  `SIDTA_ASSERT(a_digit_after_sign, (out_o.valid && out_o.ready && out_o.character == sidta_pkg::CharMinus) |=> !(out_o.valid && out_o.character == sidta_pkg::CharMinus))
  `SIDTA_NEVER(a_pop_empty, head_pop && !head_valid)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

module testbench;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 40;

  typedef struct {
    logic [sidta_pkg::ValueWidth-1:0] value;
    int                               gap;
    bit                               drain;
  } number_t;

  typedef struct {
    logic [sidta_pkg::CharWidth-1:0] character;
    logic                            last;
  } char_word_t;

  logic clk_i;
  logic rst_ni;

  sidta_in_if  in_if ();
  sidta_out_if out_if ();

  signed_int_to_decimal_ascii_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  number_t    number_q[$];
  char_word_t text_q[$];
  char_word_t want;
  number_t    nxt;
  int         outstanding;
  int         waited;
  bit         feed_done;
  int         failures;
  int         quiet_cycles;
  int         cycle_cnt;
  int         stall_left;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    out_if.ready = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  // Expected text of one number, most significant character first.
  function automatic void spell_decimal(input logic [sidta_pkg::ValueWidth-1:0] value);
    logic [sidta_pkg::ValueWidth-1:0] mag;
    logic [sidta_pkg::ValueWidth-1:0] d;
    logic [sidta_pkg::CharWidth-1:0]  digits[$];
    mag = value[sidta_pkg::ValueWidth-1] ? (~value + 1'b1) : value;
    do begin
      d = mag % 32'd10;
      digits.push_front(sidta_pkg::CharZero + d[sidta_pkg::CharWidth-1:0]);
      mag = mag / 32'd10;
    end while (mag != 0);
    if (value[sidta_pkg::ValueWidth-1]) text_q.push_back('{sidta_pkg::CharMinus, 1'b0});
    foreach (digits[i]) text_q.push_back('{digits[i], i == digits.size() - 1});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [sidta_pkg::ValueWidth-1:0] pick_value();
    logic [sidta_pkg::ValueWidth-1:0] v;
    logic [sidta_pkg::ValueWidth-1:0] lim;
    int kind;
    int k;
    kind = $urandom_range(9);
    k = $urandom_range(9, 1);
    lim = 1;
    repeat (k) lim = lim * 10;
    case (kind)
      0, 1, 2: v = $urandom;
      3, 4, 5, 6: v = $urandom_range(lim - 1);
      7: v = $urandom_range(1) ? lim : lim - 1;
      8: v = $urandom_range(20);
      default: begin
        case ($urandom_range(2))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          default: v = $urandom_range(32'd2147483647, 32'd1000000000);
        endcase
      end
    endcase
    if (kind >= 3 && $urandom_range(1)) v = ~v + 1'b1;
    return v;
  endfunction

  function automatic void add_number(input logic [sidta_pkg::ValueWidth-1:0] value,
                                     input int gap, input bit drain);
    number_q.push_back('{value, gap, drain});
  endfunction

  // Driver: present the next number once its gap has passed.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.value <= '0;
      waited <= 0;
      feed_done <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (number_q.size() == 0) begin
        in_if.valid <= 1'b0;
        feed_done <= 1'b1;
      end else if (waited < number_q[0].gap ||
                   (number_q[0].drain && (in_if.valid || outstanding != 0))) begin
        in_if.valid <= 1'b0;
        waited <= waited + 1;
      end else begin
        nxt = number_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.value <= nxt.value;
        waited <= 0;
      end
    end
  end

  // Receiver back-pressure, with calm stretches where ready stays high.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ((cycle_cnt % 1024) >= 300 && $urandom_range(5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check each character word, then queue the text of an accepted number.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (text_q.size() == 0) begin
          $error("unexpected word: character %h last %b", out_if.character, out_if.last);
          failures++;
        end else begin
          want = text_q.pop_front();
          if (out_if.character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_if.character);
            failures++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_if.last);
            failures++;
          end
        end
      end
      if (in_if.valid && in_if.ready) spell_decimal(in_if.value);
      outstanding <= text_q.size();
    end
  end

  // Watchdog: stop if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("signed_int_to_decimal_ascii_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    failures = 0;
    quiet_cycles = 0;
    add_number(32'd0, 0, 1'b0);
    add_number(32'd1, 0, 1'b0);
    add_number(-32'sd1, 0, 1'b0);
    add_number(32'd9, 1, 1'b0);
    add_number(32'd10, 0, 1'b0);
    add_number(-32'sd10, 0, 1'b0);
    add_number(32'd99, 2, 1'b0);
    add_number(32'd100, 0, 1'b0);
    add_number(32'h7FFF_FFFF, 0, 1'b0);
    add_number(32'h8000_0000, 0, 1'b0);
    add_number(32'h8000_0001, 3, 1'b0);
    add_number(32'd1000000000, 0, 1'b0);
    add_number(32'd999999999, 0, 1'b0);
    add_number(-32'sd999999999, 0, 1'b0);
    add_number(32'd1000000009, 0, 1'b0);
    add_number(32'h5555_5555, 0, 1'b0);
    add_number(32'hAAAA_AAAA, 5, 1'b0);
    add_number(32'd123456789, 0, 1'b0);
    add_number(-32'sd123456789, 0, 1'b0);
    add_number(32'd7, 0, 1'b0);
    add_number(-32'sd7, 0, 1'b0);
    // hold until the directed text has drained
    add_number(32'd0, 0, 1'b1);
    for (int i = 0; i < 410; i++) begin
      add_number(pick_value(), (i >= 150 && i < 230) ? 0 : pick_gap(), (i % 120) == 119);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(feed_done && outstanding == 0)) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (failures == 0 && text_q.size() == 0) begin
      $display("signed_int_to_decimal_ascii_core verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
